@@ src/bpmt_pkg.sv @@
package bpmt_pkg;

   localparam int TABLE_DEPTH  = 65536;
   localparam int COORD_BITS   = 10;
   localparam int ADDR_BITS    = $clog2(TABLE_DEPTH);
   localparam int DIM_BITS     = 11;
   localparam int CRD_IN_BITS  = 11;
   localparam int FOUND_BITS   = 10;
   localparam int POINT_BITS   = 2 * COORD_BITS;
   localparam int MEM_BITS     = POINT_BITS + 1;
   localparam int PROD_BITS    = 2 * DIM_BITS;
   localparam int IDX_BITS     = (PROD_BITS + 1 > ADDR_BITS + 1) ? PROD_BITS + 1 : ADDR_BITS + 1;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   typedef enum logic [1:0] {
      ACT_CLEAR = 2'd0,
      ACT_ADD   = 2'd1,
      ACT_FWD   = 2'd2,
      ACT_REV   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_READY = 2'd1,
      ST_RANGE     = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      REG_SOURCE_WIDTH  = 2'd0,
      REG_SOURCE_HEIGHT = 2'd1,
      REG_TARGET_WIDTH  = 2'd2,
      REG_TARGET_HEIGHT = 2'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MULT,
      S_CHECK,
      S_READ,
      S_DECIDE,
      S_SWEEP,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic [DIM_BITS-1:0] source_width;
      logic [DIM_BITS-1:0] source_height;
      logic [DIM_BITS-1:0] target_width;
      logic [DIM_BITS-1:0] target_height;
   } cfg_type;

   typedef struct packed {
      logic load_item;
      logic mult;
      logic check;
      logic sweep_start;
      logic read;
      logic decide;
      logic sweep_step;
      logic load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      action_type action;
      logic       sweep_last;
   } dp_status_type;

endpackage

@@ src/bpmt_if.sv @@
interface bpmt_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [1:0]                             action;
   logic signed [bpmt_pkg::CRD_IN_BITS-1:0] first_x;
   logic signed [bpmt_pkg::CRD_IN_BITS-1:0] first_y;
   logic signed [bpmt_pkg::CRD_IN_BITS-1:0] second_x;
   logic signed [bpmt_pkg::CRD_IN_BITS-1:0] second_y;

   modport source (output valid, action, first_x, first_y, second_x, second_y, input ready);
   modport sink   (input valid, action, first_x, first_y, second_x, second_y, output ready);
endinterface

interface bpmt_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [1:0]                         status;
   logic [bpmt_pkg::FOUND_BITS-1:0]    found_x;
   logic [bpmt_pkg::FOUND_BITS-1:0]    found_y;

   modport source (output valid, status, found_x, found_y, input ready);
   modport sink   (input valid, status, found_x, found_y, output ready);
endinterface

@@ src/bpmt_csr.sv @@
module bpmt_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [bpmt_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [bpmt_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [bpmt_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                 csr_pready,
   output bpmt_pkg::cfg_type                    cfg
);

   bpmt_pkg::cfg_type       cfg_ff;
   bpmt_pkg::cfg_type       cfg_in;
   bpmt_pkg::reg_index_type reg_index;
   logic                    wr_en;
   logic [bpmt_pkg::DIM_BITS-1:0] wr_value;
   logic [bpmt_pkg::DIM_BITS-1:0] rd_value;

   assign reg_index  = bpmt_pkg::reg_index_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign wr_value   = csr_pwdata[bpmt_pkg::DIM_BITS-1:0];
   assign csr_pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index)
            bpmt_pkg::REG_SOURCE_WIDTH:  cfg_in.source_width  = wr_value;
            bpmt_pkg::REG_SOURCE_HEIGHT: cfg_in.source_height = wr_value;
            bpmt_pkg::REG_TARGET_WIDTH:  cfg_in.target_width  = wr_value;
            bpmt_pkg::REG_TARGET_HEIGHT: cfg_in.target_height = wr_value;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         bpmt_pkg::REG_SOURCE_WIDTH:  rd_value = cfg_ff.source_width;
         bpmt_pkg::REG_SOURCE_HEIGHT: rd_value = cfg_ff.source_height;
         bpmt_pkg::REG_TARGET_WIDTH:  rd_value = cfg_ff.target_width;
         bpmt_pkg::REG_TARGET_HEIGHT: rd_value = cfg_ff.target_height;
         default: rd_value = '0;
      endcase
   end

   assign csr_prdata = bpmt_pkg::CSR_DATA_BITS'(rd_value);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ src/bpmt_ctrl.sv @@
module bpmt_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  bpmt_pkg::dp_status_type status,
   output bpmt_pkg::ctrl_cmd_type  cmd
);

   bpmt_pkg::state_type state_ff;
   bpmt_pkg::state_type state_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bpmt_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = bpmt_pkg::S_MULT;
            end
         end
         bpmt_pkg::S_MULT:   state_in = bpmt_pkg::S_CHECK;
         bpmt_pkg::S_CHECK: begin
            if (status.action == bpmt_pkg::ACT_CLEAR) begin
               state_in = bpmt_pkg::S_SWEEP;
            end else begin
               state_in = bpmt_pkg::S_READ;
            end
         end
         bpmt_pkg::S_READ:   state_in = bpmt_pkg::S_DECIDE;
         bpmt_pkg::S_DECIDE: state_in = bpmt_pkg::S_FINISH;
         bpmt_pkg::S_SWEEP: begin
            if (status.sweep_last) begin
               state_in = bpmt_pkg::S_FINISH;
            end
         end
         bpmt_pkg::S_FINISH: begin
            if (out_free) begin
               state_in = bpmt_pkg::S_IDLE;
            end
         end
         default: state_in = bpmt_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         bpmt_pkg::S_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
         end
         bpmt_pkg::S_MULT:   cmd.mult = 1'b1;
         bpmt_pkg::S_CHECK: begin
            cmd.check       = 1'b1;
            cmd.sweep_start = (status.action == bpmt_pkg::ACT_CLEAR);
         end
         bpmt_pkg::S_READ:   cmd.read = 1'b1;
         bpmt_pkg::S_DECIDE: cmd.decide = 1'b1;
         bpmt_pkg::S_SWEEP:  cmd.sweep_step = 1'b1;
         bpmt_pkg::S_FINISH: cmd.load_out = out_free;
         default: cmd = '0;
      endcase
   end

   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bpmt_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bpmt_pkg::S_IDLE && req_valid) |=> (state_ff == bpmt_pkg::S_MULT))
      else $error("accepted item did not start the multiply step");

   a_sweep_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bpmt_pkg::S_SWEEP && !status.sweep_last) |=>
      (state_ff == bpmt_pkg::S_SWEEP))
      else $error("clear sweep left before its last entry");

   a_finish_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bpmt_pkg::S_FINISH && out_free) |=>
      (rsp_valid_ff && state_ff == bpmt_pkg::S_IDLE))
      else $error("finished item was not presented on the result channel");
`endif

endmodule

@@ src/bpmt_datapath.sv @@
module bpmt_datapath (
   input  logic                                      clock,
   input  logic                                      reset,
   input  bpmt_pkg::ctrl_cmd_type                    cmd,
   output bpmt_pkg::dp_status_type                   status,
   input  bpmt_pkg::cfg_type                         cfg,
   input  logic [1:0]                                req_action,
   input  logic signed [bpmt_pkg::CRD_IN_BITS-1:0]   req_first_x,
   input  logic signed [bpmt_pkg::CRD_IN_BITS-1:0]   req_first_y,
   input  logic signed [bpmt_pkg::CRD_IN_BITS-1:0]   req_second_x,
   input  logic signed [bpmt_pkg::CRD_IN_BITS-1:0]   req_second_y,
   output logic [1:0]                                rsp_status,
   output logic [bpmt_pkg::FOUND_BITS-1:0]           rsp_found_x,
   output logic [bpmt_pkg::FOUND_BITS-1:0]           rsp_found_y
);

   localparam int PB = bpmt_pkg::POINT_BITS;
   localparam int CB = bpmt_pkg::COORD_BITS;
   localparam int AB = bpmt_pkg::ADDR_BITS;
   localparam int IB = bpmt_pkg::IDX_BITS;
   localparam int DB = bpmt_pkg::DIM_BITS;

   function automatic logic [PB-1:0] pack_point(
      input logic signed [bpmt_pkg::CRD_IN_BITS-1:0] x,
      input logic signed [bpmt_pkg::CRD_IN_BITS-1:0] y);
      logic [bpmt_pkg::CRD_IN_BITS-1:0] ux;
      logic [bpmt_pkg::CRD_IN_BITS-1:0] uy;
      ux = $unsigned(x);
      uy = $unsigned(y);
      return {CB'(uy), CB'(ux)};
   endfunction

   // Item registers.
   bpmt_pkg::action_type                     action_ff;
   logic signed [bpmt_pkg::CRD_IN_BITS-1:0]  ax_ff, ay_ff, bx_ff, by_ff;

   // Multiply step.
   logic [DB-1:0]                  mul_a_l, mul_a_r, mul_b_l, mul_b_r;
   logic [bpmt_pkg::PROD_BITS-1:0] prod_a_in, prod_b_in, prod_a_ff, prod_b_ff;

   // Bounds step.
   logic [DB-1:0]  dim_a_w, dim_a_h;
   logic [IB-1:0]  sum_a, sum_b;
   logic           in_a_in, in_b_in, in_a_ff, in_b_ff;
   logic [AB-1:0]  idx_a_in, rev_idx_in, idx_a_ff, rev_idx_ff;
   logic           ready_cand_in, ready_cand_ff;

   // Tables, each entry {valid, y, x}.
   logic [bpmt_pkg::MEM_BITS-1:0] fwd_mem [bpmt_pkg::TABLE_DEPTH];
   logic [bpmt_pkg::MEM_BITS-1:0] rev_mem [bpmt_pkg::TABLE_DEPTH];
   logic [bpmt_pkg::MEM_BITS-1:0] fwd_rd_ff, rev_rd_ff;
   logic                          fwd_we, rev_we;
   logic [AB-1:0]                 fwd_wa, rev_wa;
   logic [bpmt_pkg::MEM_BITS-1:0] fwd_wd, rev_wd;
   logic                          add_ok;

   logic [AB-1:0] sweep_cnt_ff, sweep_cnt_in;
   logic          sweep_last;
   logic          tables_ready_ff;

   // Result and output registers.
   bpmt_pkg::status_type           res_status_in, res_status_ff, out_status_ff;
   logic [bpmt_pkg::FOUND_BITS-1:0] res_x_in, res_y_in, res_x_ff, res_y_ff;
   logic [bpmt_pkg::FOUND_BITS-1:0] out_x_ff, out_y_ff;
   logic [bpmt_pkg::MEM_BITS-1:0]  sel_rd;
   logic                           res_load;

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         action_ff <= bpmt_pkg::action_type'(req_action);
         ax_ff     <= req_first_x;
         ay_ff     <= req_first_y;
         bx_ff     <= req_second_x;
         by_ff     <= req_second_y;
      end
   end

   // A clear multiplies the view sizes, the other actions form y*width.
   always_comb begin
      mul_a_l = (action_ff == bpmt_pkg::ACT_REV) ? cfg.target_width : cfg.source_width;
      mul_a_r = (action_ff == bpmt_pkg::ACT_CLEAR) ? cfg.source_height : $unsigned(ay_ff);
      mul_b_l = cfg.target_width;
      mul_b_r = (action_ff == bpmt_pkg::ACT_CLEAR) ? cfg.target_height : $unsigned(by_ff);
      prod_a_in = bpmt_pkg::PROD_BITS'(mul_a_l) * bpmt_pkg::PROD_BITS'(mul_a_r);
      prod_b_in = bpmt_pkg::PROD_BITS'(mul_b_l) * bpmt_pkg::PROD_BITS'(mul_b_r);
   end

   always_ff @(posedge clock) begin
      if (cmd.mult) begin
         prod_a_ff <= prod_a_in;
         prod_b_ff <= prod_b_in;
      end
   end

   always_comb begin
      dim_a_w = (action_ff == bpmt_pkg::ACT_REV) ? cfg.target_width  : cfg.source_width;
      dim_a_h = (action_ff == bpmt_pkg::ACT_REV) ? cfg.target_height : cfg.source_height;
      sum_a   = IB'(prod_a_ff) + IB'($unsigned(ax_ff));
      sum_b   = IB'(prod_b_ff) + IB'($unsigned(bx_ff));
      in_a_in = !ax_ff[bpmt_pkg::CRD_IN_BITS-1] && !ay_ff[bpmt_pkg::CRD_IN_BITS-1] &&
                ($unsigned(ax_ff) < dim_a_w) && ($unsigned(ay_ff) < dim_a_h) &&
                (sum_a < IB'(bpmt_pkg::TABLE_DEPTH));
      in_b_in = !bx_ff[bpmt_pkg::CRD_IN_BITS-1] && !by_ff[bpmt_pkg::CRD_IN_BITS-1] &&
                ($unsigned(bx_ff) < cfg.target_width) &&
                ($unsigned(by_ff) < cfg.target_height) &&
                (sum_b < IB'(bpmt_pkg::TABLE_DEPTH));
      idx_a_in   = sum_a[AB-1:0];
      rev_idx_in = (action_ff == bpmt_pkg::ACT_ADD) ? sum_b[AB-1:0] : sum_a[AB-1:0];
      ready_cand_in = (cfg.source_width != '0) && (cfg.source_height != '0) &&
                      (cfg.target_width != '0) && (cfg.target_height != '0) &&
                      (IB'(prod_a_ff) <= IB'(bpmt_pkg::TABLE_DEPTH)) &&
                      (IB'(prod_b_ff) <= IB'(bpmt_pkg::TABLE_DEPTH));
   end

   always_ff @(posedge clock) begin
      if (cmd.check) begin
         in_a_ff       <= in_a_in;
         in_b_ff       <= in_b_in;
         idx_a_ff      <= idx_a_in;
         rev_idx_ff    <= rev_idx_in;
         ready_cand_ff <= ready_cand_in;
      end
   end

   assign sweep_last = (sweep_cnt_ff == AB'(bpmt_pkg::TABLE_DEPTH - 1));

   always_comb begin
      if (cmd.sweep_start) begin
         sweep_cnt_in = '0;
      end else if (cmd.sweep_step) begin
         sweep_cnt_in = sweep_cnt_ff + AB'(1);
      end else begin
         sweep_cnt_in = sweep_cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_cnt_ff    <= '0;
         tables_ready_ff <= 1'b0;
      end else begin
         sweep_cnt_ff <= sweep_cnt_in;
         if (cmd.sweep_step && sweep_last) begin
            tables_ready_ff <= ready_cand_ff;
         end
      end
   end

   always_comb begin
      add_ok = tables_ready_ff && in_a_ff && in_b_ff && (action_ff == bpmt_pkg::ACT_ADD);
      fwd_we = cmd.sweep_step || (cmd.decide && add_ok && !fwd_rd_ff[PB]);
      rev_we = cmd.sweep_step || (cmd.decide && add_ok && !rev_rd_ff[PB]);
      fwd_wa = cmd.sweep_step ? sweep_cnt_ff : idx_a_ff;
      rev_wa = cmd.sweep_step ? sweep_cnt_ff : rev_idx_ff;
      fwd_wd = cmd.sweep_step ? '0 : {1'b1, pack_point(bx_ff, by_ff)};
      rev_wd = cmd.sweep_step ? '0 : {1'b1, pack_point(ax_ff, ay_ff)};
   end

   always_ff @(posedge clock) begin
      if (fwd_we) begin
         fwd_mem[fwd_wa] <= fwd_wd;
      end
      if (cmd.read) begin
         fwd_rd_ff <= fwd_mem[idx_a_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (rev_we) begin
         rev_mem[rev_wa] <= rev_wd;
      end
      if (cmd.read) begin
         rev_rd_ff <= rev_mem[rev_idx_ff];
      end
   end

   always_comb begin
      sel_rd        = (action_ff == bpmt_pkg::ACT_FWD) ? fwd_rd_ff : rev_rd_ff;
      res_status_in = bpmt_pkg::ST_OK;
      res_x_in      = '0;
      res_y_in      = '0;
      if (action_ff == bpmt_pkg::ACT_CLEAR) begin
         res_status_in = ready_cand_ff ? bpmt_pkg::ST_OK : bpmt_pkg::ST_NOT_READY;
      end else if (!tables_ready_ff) begin
         res_status_in = bpmt_pkg::ST_NOT_READY;
      end else begin
         case (action_ff)
            bpmt_pkg::ACT_ADD: begin
               res_status_in = (in_a_ff && in_b_ff) ? bpmt_pkg::ST_OK : bpmt_pkg::ST_RANGE;
            end
            bpmt_pkg::ACT_FWD, bpmt_pkg::ACT_REV: begin
               if (!in_a_ff) begin
                  res_status_in = bpmt_pkg::ST_RANGE;
               end else if (!sel_rd[PB]) begin
                  res_status_in = bpmt_pkg::ST_EMPTY;
               end else begin
                  res_x_in = bpmt_pkg::FOUND_BITS'(sel_rd[CB-1:0]);
                  res_y_in = bpmt_pkg::FOUND_BITS'(sel_rd[PB-1:CB]);
               end
            end
            default: res_status_in = bpmt_pkg::ST_OK;
         endcase
      end
   end

   assign res_load = cmd.decide || (cmd.sweep_step && sweep_last);

   always_ff @(posedge clock) begin
      if (res_load) begin
         res_status_ff <= res_status_in;
         res_x_ff      <= res_x_in;
         res_y_ff      <= res_y_in;
      end
      if (cmd.load_out) begin
         out_status_ff <= res_status_ff;
         out_x_ff      <= res_x_ff;
         out_y_ff      <= res_y_ff;
      end
   end

   assign status.action     = action_ff;
   assign status.sweep_last = sweep_last;
   assign rsp_status        = out_status_ff;
   assign rsp_found_x       = out_x_ff;
   assign rsp_found_y       = out_y_ff;

`ifndef SYNTHESIS
   a_add_write_legal: assert property (@(posedge clock) disable iff (reset)
      (cmd.decide && fwd_we) |-> (action_ff == bpmt_pkg::ACT_ADD && in_a_ff && in_b_ff &&
      tables_ready_ff))
      else $error("table written by an item that may not write");

   a_found_zero: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> (out_status_ff == bpmt_pkg::ST_OK ||
      (out_x_ff == '0 && out_y_ff == '0)))
      else $error("point reported with a failing status");
`endif

endmodule

@@ src/bidirectional_point_map_table_core.sv @@
// Sequence: an add or lookup item steps through the multiply, check, read, decide and
// finish states, and its result is registered on leaving finish; a clear item runs the
// sweep in place of read and decide. A new item is taken only back in idle, once the
// previous one has left finish; the sweep over the valid marks sets the clear time.
// Reset: synchronous, active high; sizes read as zero and the tables as not ready, so no
// clearing pass runs after reset and the first clear item arms the tables.
module bidirectional_point_map_table_core (
   input  logic                                clock,
   input  logic                                reset,
   bpmt_req_if.sink                            req_if,
   bpmt_rsp_if.source                          rsp_if,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [bpmt_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [bpmt_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [bpmt_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready
);

   // The view sizes live in a small register file on the configuration port. They are
   // read live by the datapath, so bounds and indexing always follow the current values.
   bpmt_pkg::cfg_type       cfg;

   // The controller sequences each item through multiply, bounds check, table read and
   // decision steps, or through the clearing sweep; the datapath only acts on its commands.
   bpmt_pkg::ctrl_cmd_type  cmd;
   bpmt_pkg::dp_status_type dp_status;

   logic req_ready;
   logic rsp_valid;

   bpmt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // The result sits in an output register, so a new item is taken while the previous
   // result still waits for the sink.
   bpmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_if.ready),
      .status    (dp_status),
      .cmd       (cmd)
   );

   // Both tables are single memories of {valid, point} words. An add reads both entries
   // and writes only those still empty, so the first pair written in each direction wins.
   bpmt_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (dp_status),
      .cfg          (cfg),
      .req_action   (req_if.action),
      .req_first_x  (req_if.first_x),
      .req_first_y  (req_if.first_y),
      .req_second_x (req_if.second_x),
      .req_second_y (req_if.second_y),
      .rsp_status   (rsp_if.status),
      .rsp_found_x  (rsp_if.found_x),
      .rsp_found_y  (rsp_if.found_y)
   );

   assign req_if.ready = req_ready;
   assign rsp_if.valid = rsp_valid;

endmodule
